/* src/hpdr_pkg.sv */
package hpdr_pkg;

  // Request codes carried on the input tuser
  localparam logic [2:0] REQ_TICK     = 3'd0;
  localparam logic [2:0] REQ_SETPOINT = 3'd1;
  localparam logic [2:0] REQ_POSE     = 3'd2;
  localparam logic [2:0] REQ_RATE     = 3'd3;
  localparam logic [2:0] REQ_DEPTH    = 3'd4;

  // Register indexes (byte address is 4 times the index)
  localparam logic [2:0] REG_GAIN_P       = 3'd0;
  localparam logic [2:0] REG_GAIN_D       = 3'd1;
  localparam logic [2:0] REG_CRUISE_SPEED = 3'd2;
  localparam logic [2:0] REG_RATE_LIMIT   = 3'd3;
  localparam logic [2:0] REG_DEPTH_CUTOFF = 3'd4;
  localparam logic [2:0] REG_FRESH_TICKS  = 3'd5;

  // Register reset values
  localparam logic [15:0]        GAIN_P_RST       = 16'd4096;
  localparam logic [15:0]        GAIN_D_RST       = 16'd819;
  localparam logic signed [15:0] CRUISE_SPEED_RST = 16'sd4096;
  localparam logic [14:0]        RATE_LIMIT_RST   = 15'd4096;
  localparam logic signed [15:0] DEPTH_CUTOFF_RST = 16'sd500;
  localparam logic [15:0]        FRESH_TICKS_RST  = 16'd10;

  // 2*pi in Q28
  localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;

  // Set point scaling: ceil(2^40 / 225) and the rounding offset 1800/16
  localparam logic [32:0] SP_RECIP225 = 33'd4886718346;
  localparam int unsigned SP_RECIP_SHIFT = 40;
  localparam logic [23:0] SP_ROUND = 24'd112;

  typedef struct packed {
    logic [15:0]        gain_p;
    logic [15:0]        gain_d;
    logic signed [15:0] cruise_speed;
    logic [14:0]        rate_limit;
    logic signed [15:0] depth_cutoff;
    logic [15:0]        fresh_ticks;
  } cfg_t;

  // x / 2^12 rounded to nearest, halves away from zero
  function automatic logic signed [23:0] rnd12(input logic signed [34:0] x);
    logic [34:0] mag;
    logic [34:0] sum;
    logic [23:0] r;
    mag = x[34] ? 35'(-x) : 35'(x);
    sum = mag + 35'd2048;
    r   = {1'b0, sum[34:12]};
    return x[34] ? $signed(-r) : $signed(r);
  endfunction

  // Saturate to 16-bit signed
  function automatic logic signed [15:0] sat16(input logic signed [23:0] x);
    logic signed [15:0] y;
    if (x > 24'sd32767) begin
      y = 16'sh7fff;
    end else if (x < -24'sd32768) begin
      y = 16'sh8000;
    end else begin
      y = x[15:0];
    end
    return y;
  endfunction

endpackage

/* src/hpdr_cfg.sv */
module hpdr_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output hpdr_pkg::cfg_t      cfg
);

  hpdr_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  // Register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p       <= hpdr_pkg::GAIN_P_RST;
      cfg_r.gain_d       <= hpdr_pkg::GAIN_D_RST;
      cfg_r.cruise_speed <= hpdr_pkg::CRUISE_SPEED_RST;
      cfg_r.rate_limit   <= hpdr_pkg::RATE_LIMIT_RST;
      cfg_r.depth_cutoff <= hpdr_pkg::DEPTH_CUTOFF_RST;
      cfg_r.fresh_ticks  <= hpdr_pkg::FRESH_TICKS_RST;
    end else if (wr_en) begin
      case (reg_idx)
        hpdr_pkg::REG_GAIN_P:       cfg_r.gain_p       <= pwdata[15:0];
        hpdr_pkg::REG_GAIN_D:       cfg_r.gain_d       <= pwdata[15:0];
        hpdr_pkg::REG_CRUISE_SPEED: cfg_r.cruise_speed <= pwdata[15:0];
        hpdr_pkg::REG_RATE_LIMIT:   cfg_r.rate_limit   <= pwdata[14:0];
        hpdr_pkg::REG_DEPTH_CUTOFF: cfg_r.depth_cutoff <= pwdata[15:0];
        hpdr_pkg::REG_FRESH_TICKS:  cfg_r.fresh_ticks  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      hpdr_pkg::REG_GAIN_P:       prdata = {16'd0, cfg_r.gain_p};
      hpdr_pkg::REG_GAIN_D:       prdata = {16'd0, cfg_r.gain_d};
      hpdr_pkg::REG_CRUISE_SPEED: prdata = {16'd0, cfg_r.cruise_speed};
      hpdr_pkg::REG_RATE_LIMIT:   prdata = {17'd0, cfg_r.rate_limit};
      hpdr_pkg::REG_DEPTH_CUTOFF: prdata = {16'd0, cfg_r.depth_cutoff};
      hpdr_pkg::REG_FRESH_TICKS:  prdata = {16'd0, cfg_r.fresh_ticks};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

/* src/hpdr_front.sv */
module hpdr_front #(
  parameter int ANGLE_BITS = 16,
  parameter int AGE_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hpdr_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_type,
  input  logic signed [15:0]            in_value,
  output logic                          tk_valid,
  input  logic                          tk_ready,
  output logic signed [ANGLE_BITS+31:0] tk_prod,
  output logic signed [15:0]            tk_rate,
  output logic                          tk_act
);

  localparam int unsigned KSCALE = 1 << (ANGLE_BITS - 4);
  localparam logic [ANGLE_BITS-1:0] KQ = ANGLE_BITS'(KSCALE / 225);
  localparam logic [7:0] KR = 8'(KSCALE % 225);
  localparam int CW = (AGE_BITS > 16) ? AGE_BITS : 16;
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  // Stage 1: input register
  logic                  v1_r;
  logic [2:0]            typ1_r;
  logic signed [15:0]    val1_r;

  // Stage 2: set point partial products, state update on exit
  logic                  v2_r;
  logic [2:0]            typ2_r;
  logic signed [15:0]    val2_r;
  logic                  neg2_r;
  logic [22:0]           lo2_r;
  logic [ANGLE_BITS-1:0] hi2_r;

  // Stage 3: tick product towards the control law
  logic                         v3_r;
  logic signed [ANGLE_BITS+31:0] prod3_r;
  logic signed [15:0]           rate3_r;
  logic                         act3_r;

  // Regulator state
  logic [ANGLE_BITS-1:0] target_r, target_nxt;
  logic [ANGLE_BITS-1:0] pose_r, pose_nxt;
  logic signed [15:0]    rate_r;
  logic signed [15:0]    depth_r;
  logic [AGE_BITS-1:0]   age_sp_r, age_pose_r;

  logic move1, can2, leave2, can3, tick_go;

  // Pipeline flow control
  assign can3     = !v3_r || tk_ready;
  assign leave2   = v2_r && ((typ2_r != hpdr_pkg::REQ_TICK) || can3);
  assign can2     = !v2_r || leave2;
  assign move1    = v1_r && can2;
  assign in_ready = !v1_r || can2;
  assign tick_go  = leave2 && (typ2_r == hpdr_pkg::REQ_TICK);

  assign tk_valid = v3_r;
  assign tk_prod  = prod3_r;
  assign tk_rate  = rate3_r;
  assign tk_act   = act3_r;

  // Stage 1 capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_ready) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      typ1_r <= in_type;
      val1_r <= in_value;
    end
  end

  // Set point: |sp| * 2^(A-4) = 225*(|sp|*KQ) + |sp|*KR, split for the divide by 225
  logic [15:0]             s_abs;
  logic [23:0]             lo_full;
  logic [ANGLE_BITS+15:0]  hi_full;

  always_comb begin
    s_abs   = val1_r[15] ? 16'(-val1_r) : 16'(val1_r);
    lo_full = s_abs * KR + hpdr_pkg::SP_ROUND;
    hi_full = s_abs * KQ;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (can2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (move1) begin
      typ2_r <= typ1_r;
      val2_r <= val1_r;
      neg2_r <= val1_r[15];
      lo2_r  <= lo_full[22:0];
      hi2_r  <= hi_full[ANGLE_BITS-1:0];
    end
  end

  // Finish the set point conversion
  logic [55:0]            q_prod;
  logic [ANGLE_BITS+15:0] q_ext;
  logic [ANGLE_BITS-1:0]  sp_mag;

  always_comb begin
    q_prod     = lo2_r * hpdr_pkg::SP_RECIP225;
    q_ext      = (ANGLE_BITS + 16)'(q_prod[55:hpdr_pkg::SP_RECIP_SHIFT]);
    sp_mag     = hi2_r + q_ext[ANGLE_BITS-1:0];
    target_nxt = neg2_r ? ANGLE_BITS'(-sp_mag) : sp_mag;
  end

  // Yaw binary angle to the internal angle width
  logic [ANGLE_BITS+15:0] raw_w;
  assign raw_w = (ANGLE_BITS + 16)'(val2_r);

  generate
    if (ANGLE_BITS >= 16) begin : g_pose_up
      logic [ANGLE_BITS+15:0] pose_w;
      assign pose_w   = raw_w << (ANGLE_BITS - 16);
      assign pose_nxt = pose_w[ANGLE_BITS-1:0];
    end else begin : g_pose_down
      logic [ANGLE_BITS+15:0] pose_w;
      assign pose_w   = raw_w >> (16 - ANGLE_BITS);
      assign pose_nxt = pose_w[ANGLE_BITS-1:0];
    end
  endgenerate

  // Tick evaluation: heading error times 2*pi, freshness and depth check
  logic signed [ANGLE_BITS-1:0]  err_ang;
  logic signed [ANGLE_BITS+31:0] prod_nxt;
  logic [CW-1:0]                 age_sp_w, age_pose_w, fresh_w;
  logic                          act_nxt;

  always_comb begin
    err_ang    = $signed(pose_r - target_r);
    prod_nxt   = err_ang * $signed({1'b0, hpdr_pkg::TWO_PI_Q28});
    age_sp_w   = CW'(age_sp_r);
    age_pose_w = CW'(age_pose_r);
    fresh_w    = CW'(cfg.fresh_ticks);
    act_nxt    = (age_sp_w < fresh_w) && (age_pose_w < fresh_w) &&
                 (depth_r < cfg.depth_cutoff);
  end

  // Update the stored operands as each event leaves stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r   <= '0;
      pose_r     <= '0;
      rate_r     <= '0;
      depth_r    <= '0;
      age_sp_r   <= AGE_MAX;
      age_pose_r <= AGE_MAX;
    end else if (leave2) begin
      case (typ2_r)
        hpdr_pkg::REQ_TICK: begin
          if (age_sp_r != AGE_MAX) begin
            age_sp_r <= age_sp_r + 1'b1;
          end
          if (age_pose_r != AGE_MAX) begin
            age_pose_r <= age_pose_r + 1'b1;
          end
        end
        hpdr_pkg::REQ_SETPOINT: begin
          target_r <= target_nxt;
          age_sp_r <= '0;
        end
        hpdr_pkg::REQ_POSE: begin
          pose_r     <= pose_nxt;
          age_pose_r <= '0;
        end
        hpdr_pkg::REQ_RATE:  rate_r  <= val2_r;
        hpdr_pkg::REQ_DEPTH: depth_r <= val2_r;
        default: ;
      endcase
    end
  end

  // Stage 3: hold the tick until the control law takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (can3) begin
      v3_r <= tick_go;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_go) begin
      prod3_r <= prod_nxt;
      rate3_r <= rate_r;
      act3_r  <= act_nxt;
    end
  end

endmodule

/* src/hpdr_law.sv */
module hpdr_law #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hpdr_pkg::cfg_t                cfg,
  input  logic                          tk_valid,
  output logic                          tk_ready,
  input  logic signed [ANGLE_BITS+31:0] tk_prod,
  input  logic signed [15:0]            tk_rate,
  input  logic                          tk_act,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [87:0]                   out_data
);

  localparam logic [ANGLE_BITS+31:0] ERR_HALF =
    (ANGLE_BITS + 32)'(1) << (ANGLE_BITS + 15);

  logic va_r, vb_r, vc_r;
  logic cana, canb, canc, movea, moveb;

  // Stage A: error in radians
  logic signed [15:0] err_a_r, rate_a_r;
  logic               act_a_r;
  // Stage B: gain products
  logic signed [34:0] pp_b_r, dp_b_r;
  logic signed [15:0] err_b_r;
  logic               act_b_r;
  // Stage C: result register
  logic [87:0]        data_c_r;

  // Flow control
  assign canc     = !vc_r || out_ready;
  assign moveb    = vb_r && canc;
  assign canb     = !vb_r || canc;
  assign movea    = va_r && canb;
  assign cana     = !va_r || canb;
  assign tk_ready = cana;

  assign out_valid = vc_r;
  assign out_data  = data_c_r;

  // Round the Q28 product to Q4.12 radians
  logic [ANGLE_BITS+31:0] prod_mag, prod_rnd;
  logic [15:0]            err_mag;
  logic signed [15:0]     err_nxt;

  always_comb begin
    prod_mag = tk_prod[ANGLE_BITS+31] ? (ANGLE_BITS + 32)'(-tk_prod)
                                      : (ANGLE_BITS + 32)'(tk_prod);
    prod_rnd = prod_mag + ERR_HALF;
    err_mag  = prod_rnd[ANGLE_BITS+31:ANGLE_BITS+16];
    err_nxt  = tk_prod[ANGLE_BITS+31] ? $signed(-err_mag) : $signed(err_mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (cana) begin
      va_r <= tk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tk_valid && cana) begin
      err_a_r  <= err_nxt;
      rate_a_r <= tk_rate;
      act_a_r  <= tk_act;
    end
  end

  // Gain products
  logic signed [34:0] pp_nxt, dp_nxt;

  always_comb begin
    pp_nxt = $signed({1'b0, cfg.gain_p}) * err_a_r;
    dp_nxt = $signed({1'b0, cfg.gain_d}) * rate_a_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (canb) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (movea) begin
      pp_b_r  <= pp_nxt;
      dp_b_r  <= dp_nxt;
      err_b_r <= err_a_r;
      act_b_r <= act_a_r;
    end
  end

  // Round, saturate, clamp and gate the commands
  logic signed [34:0] sum_pd;
  logic signed [23:0] cmd_raw, lim, neg_lim;
  logic signed [15:0] p_term, d_term, cmd_clamped;
  logic signed [15:0] linear_cmd, angular_cmd;
  logic               limited, active, was_limited;
  logic [87:0]        data_nxt;

  always_comb begin
    sum_pd  = pp_b_r + dp_b_r;
    cmd_raw = hpdr_pkg::rnd12(sum_pd);
    p_term  = hpdr_pkg::sat16(hpdr_pkg::rnd12(pp_b_r));
    d_term  = hpdr_pkg::sat16(hpdr_pkg::rnd12(dp_b_r));
    lim     = $signed({9'd0, cfg.rate_limit});
    neg_lim = -lim;
    if (cmd_raw > lim) begin
      cmd_clamped = lim[15:0];
      limited     = 1'b1;
    end else if (cmd_raw < neg_lim) begin
      cmd_clamped = neg_lim[15:0];
      limited     = 1'b1;
    end else begin
      cmd_clamped = cmd_raw[15:0];
      limited     = 1'b0;
    end
    active      = act_b_r;
    linear_cmd  = active ? cfg.cruise_speed : 16'sd0;
    angular_cmd = active ? cmd_clamped : 16'sd0;
    was_limited = active && limited;
    data_nxt    = {6'd0, was_limited, d_term, p_term, err_b_r, active,
                   angular_cmd, linear_cmd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (canc) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (moveb) begin
      data_c_r <= data_nxt;
    end
  end

endmodule

/* src/heading_pd_regulator_top.sv */
// Heading PD regulator with command saturation.
// Input stream: in_tuser carries the request kind (tick, set point, yaw pose,
// yaw rate, depth) and in_tdata the 16-bit sample. Set point, pose, rate and
// depth events only update stored operands and give no result; each tick gives
// exactly one result transaction on the output stream.
// Output tdata holds the linear and angular commands (zero while inactive),
// the active flag, the heading error in Q4.12 radians, the saturated P and D
// parts and the clamp flag.
// Throughput: one transaction per cycle on the input unless the output stalls.
// A tick passes six register stages (input, set point scaling, tick product,
// error, gain products, result). A stalled output backs up the stages one by
// one; the input keeps accepting until every stage holds a transaction, so
// nothing is lost or repeated. Configuration must be written over the APB port
// only while the block is idle; the block does not enforce this. Reset
// (synchronous, active low) empties the stages, restores the register
// defaults, clears the stored operands and marks set point and pose as stale.
module heading_pd_regulator_top #(
  parameter int ANGLE_BITS = 16,
  parameter int AGE_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample_value
  input  logic [2:0]  in_tuser,   // [2:0] req_type
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] linear_cmd, [31:16] angular_cmd, [32] active, [48:33] heading_error,
  // [64:49] p_term, [80:65] d_term, [81] was_limited, [87:82] zero
  output logic [87:0] out_tdata,
  // Configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  hpdr_pkg::cfg_t cfg;

  logic                          tk_valid;
  logic                          tk_ready;
  logic signed [ANGLE_BITS+31:0] tk_prod;
  logic signed [15:0]            tk_rate;
  logic                          tk_act;

  assign cfg_pready = 1'b1;

  hpdr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  hpdr_front #(
    .ANGLE_BITS (ANGLE_BITS),
    .AGE_BITS   (AGE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_type  (in_tuser),
    .in_value ($signed(in_tdata)),
    .tk_valid (tk_valid),
    .tk_ready (tk_ready),
    .tk_prod  (tk_prod),
    .tk_rate  (tk_rate),
    .tk_act   (tk_act)
  );

  hpdr_law #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_law (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .tk_valid  (tk_valid),
    .tk_ready  (tk_ready),
    .tk_prod   (tk_prod),
    .tk_rate   (tk_rate),
    .tk_act    (tk_act),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule
